// File: rtl/lbp3_pkg.sv
// Package for the 3x3 local binary pattern core: sizes, register indexes
// and the window item type passed from the front end to the back end.
// No dependencies.
`timescale 1ns / 1ps

package lbp3_pkg;

   // Image geometry
   localparam int MAX_WIDTH    = 2048;
   localparam int MAX_HEIGHT   = 4096;
   localparam int MIN_DIM      = 3;
   localparam int WIDTH_RESET  = 640;
   localparam int HEIGHT_RESET = 480;

   // Field and register widths
   localparam int PIX_W        = 8;
   localparam int COL_W        = $clog2(MAX_WIDTH);
   localparam int ROW_W        = $clog2(MAX_HEIGHT);
   localparam int WIDTH_REG_W  = 12;
   localparam int HEIGHT_REG_W = 13;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 13;

   // Line store word: row above in the low byte, two rows above in the high byte
   localparam int LINE_W       = 2 * PIX_W;

   // Depth of the queue between front and back end
   localparam int QUEUE_DEPTH  = 2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = CSR_IDX_W'(1);

   typedef logic [PIX_W-1:0] pixel_type;

   // One window column, element 0 is the top row
   typedef pixel_type [2:0] column_type;

   // Full 3x3 window plus the position tags of its centre pixel
   typedef struct packed {
      column_type           left;
      column_type           mid;
      column_type           right;
      logic [ROW_W-1:0]     centre_row;
      logic [COL_W-1:0]     centre_col;
      logic                 last_of_frame;
   } job_type;

endpackage

// File: rtl/lbp3_if.sv
// Channel interfaces of the LBP core: pixel input, code output and
// register write. Depends on lbp3_pkg.
`timescale 1ns / 1ps

interface lbp3_req_if;
   import lbp3_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

interface lbp3_rsp_if;
   import lbp3_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pattern_code;
   logic [ROW_W-1:0] centre_row;
   logic [COL_W-1:0] centre_col;
   logic             last_of_frame;

   modport source (output valid, output pattern_code, output centre_row,
                   output centre_col, output last_of_frame, input ready);
   modport sink   (input valid, input pattern_code, input centre_row,
                   input centre_col, input last_of_frame, output ready);
endinterface

interface lbp3_csr_if;
   import lbp3_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/lbp3_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`timescale 1ns / 1ps

module lbp3_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/lbp3_front.sv
// Front end of the LBP core: register file, raster counters, line store
// and window. Emits one window item per interior pixel.
// Depends on lbp3_pkg, lbp3_if and lbp3_ram.
`timescale 1ns / 1ps

module lbp3_front (
   input  logic             clock,
   input  logic             reset,
   lbp3_req_if.sink         req,
   lbp3_csr_if.sink         csr,
   output logic             push_valid,
   output lbp3_pkg::job_type push_job,
   input  logic             push_ready
);
   import lbp3_pkg::*;

   // Pixel waiting for its line store read data
   typedef struct packed {
      pixel_type        pixel;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] centre_row;
      logic [COL_W-1:0] centre_col;
      logic             interior;
      logic             last;
   } stage_type;

   logic [COL_W-1:0]        col_last_ff, col_last_in;
   logic [ROW_W-1:0]        row_last_ff, row_last_in;
   logic [COL_W-1:0]        col_ff, col_in;
   logic [ROW_W-1:0]        row_ff, row_in;
   logic                    s1_valid_ff, s1_valid_in;
   stage_type               s1_ff, s1_in;
   column_type              mid_ff, mid_in;
   column_type              right_ff, right_in;

   logic                    accept;
   logic                    advance;
   logic                    csr_write;
   logic [WIDTH_REG_W-1:0]  width_val;
   logic [HEIGHT_REG_W-1:0] height_val;
   logic [LINE_W-1:0]       line_rd;
   column_type              new_col;

   assign csr.ready  = 1'b1;
   assign csr_write  = csr.valid & csr.ready;
   assign width_val  = csr.data[WIDTH_REG_W-1:0];
   assign height_val = csr.data[HEIGHT_REG_W-1:0];

   // Stage 1 moves on when its item needs no queue slot or one is free
   assign advance   = s1_valid_ff & (~s1_ff.interior | push_ready);
   assign req.ready = ~s1_valid_ff | advance;
   assign accept    = req.valid & req.ready;

   // Line store: read at the new pixel's column, write back as it leaves stage 1
   lbp3_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (advance),
      .wr_addr (s1_ff.col),
      .wr_data ({line_rd[PIX_W-1:0], s1_ff.pixel}),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (line_rd)
   );

   // Newest window column: two rows above, row above, current pixel
   assign new_col[0] = line_rd[LINE_W-1:PIX_W];
   assign new_col[1] = line_rd[PIX_W-1:0];
   assign new_col[2] = s1_ff.pixel;

   // Item towards the back end
   assign push_valid             = s1_valid_ff & s1_ff.interior;
   assign push_job.left          = mid_ff;
   assign push_job.mid           = right_ff;
   assign push_job.right         = new_col;
   assign push_job.centre_row    = s1_ff.centre_row;
   assign push_job.centre_col    = s1_ff.centre_col;
   assign push_job.last_of_frame = s1_ff.last;

   // Size registers (kept as last index, clamped) and raster counters
   always_comb begin
      col_last_in = col_last_ff;
      row_last_in = row_last_ff;
      col_in      = col_ff;
      row_in      = row_ff;

      if (accept) begin
         if (col_ff == col_last_ff) begin
            col_in = '0;
            row_in = (row_ff == row_last_ff) ? '0 : ROW_W'(row_ff + ROW_W'(1));
         end else begin
            col_in = COL_W'(col_ff + COL_W'(1));
         end
      end

      if (csr_write) begin
         case (csr.index)
            CSR_IMAGE_WIDTH: begin
               if (width_val < WIDTH_REG_W'(MIN_DIM)) begin
                  col_last_in = COL_W'(MIN_DIM - 1);
               end else if (width_val > WIDTH_REG_W'(MAX_WIDTH)) begin
                  col_last_in = COL_W'(MAX_WIDTH - 1);
               end else begin
                  col_last_in = COL_W'(width_val - WIDTH_REG_W'(1));
               end
               col_in = '0;
               row_in = '0;
            end
            CSR_IMAGE_HEIGHT: begin
               if (height_val < HEIGHT_REG_W'(MIN_DIM)) begin
                  row_last_in = ROW_W'(MIN_DIM - 1);
               end else if (height_val > HEIGHT_REG_W'(MAX_HEIGHT)) begin
                  row_last_in = ROW_W'(MAX_HEIGHT - 1);
               end else begin
                  row_last_in = ROW_W'(height_val - HEIGHT_REG_W'(1));
               end
               col_in = '0;
               row_in = '0;
            end
            default: ;
         endcase
      end
   end

   // Stage 1 valid and its tags
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end

      s1_in = s1_ff;
      if (accept) begin
         s1_in.pixel      = req.pixel;
         s1_in.col        = col_ff;
         s1_in.centre_row = ROW_W'(row_ff - ROW_W'(1));
         s1_in.centre_col = COL_W'(col_ff - COL_W'(1));
         s1_in.interior   = (row_ff >= ROW_W'(2)) && (col_ff >= COL_W'(2));
         s1_in.last       = (row_ff == row_last_ff) && (col_ff == col_last_ff);
      end
   end

   // Window shifts one column per pixel leaving stage 1
   always_comb begin
      mid_in   = mid_ff;
      right_in = right_ff;
      if (advance) begin
         mid_in   = right_ff;
         right_in = new_col;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_last_ff <= COL_W'(WIDTH_RESET - 1);
         row_last_ff <= ROW_W'(HEIGHT_RESET - 1);
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_last_ff <= col_last_in;
         row_last_ff <= row_last_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      s1_ff    <= s1_in;
      mid_ff   <= mid_in;
      right_ff <= right_in;
   end

endmodule

// File: rtl/lbp3_fifo.sv
// Short queue of window items between the front and back end of the
// LBP core. Depends on lbp3_pkg.
`timescale 1ns / 1ps

module lbp3_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  lbp3_pkg::job_type push_job,
   output logic              push_ready,
   output logic              pop_valid,
   output lbp3_pkg::job_type pop_job,
   input  logic              pop_ready
);
   import lbp3_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   // Pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                   : PTR_W'(wr_ptr_ff + PTR_W'(1));
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                   : PTR_W'(rd_ptr_ff + PTR_W'(1));
      end
      if (do_push && !do_pop) begin
         count_in = CNT_W'(count_ff + CNT_W'(1));
      end else if (do_pop && !do_push) begin
         count_in = CNT_W'(count_ff - CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// File: rtl/lbp3_back.sv
// Back end of the LBP core: compares the eight neighbours with the centre
// and holds the result in the output register. Depends on lbp3_pkg, lbp3_if.
`timescale 1ns / 1ps

module lbp3_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   input  lbp3_pkg::job_type pop_job,
   output logic              pop_ready,
   lbp3_rsp_if.source        rsp
);
   import lbp3_pkg::*;

   logic             out_valid_ff, out_valid_in;
   logic [PIX_W-1:0] code_ff, code_in;
   logic [ROW_W-1:0] row_ff;
   logic [COL_W-1:0] col_ff;
   logic             last_ff;
   logic             take;
   pixel_type        centre;

   assign pop_ready = ~out_valid_ff | rsp.ready;
   assign take      = pop_valid & pop_ready;
   assign centre    = pop_job.mid[1];

   // Clockwise from top-left: one bit per neighbour above the centre
   always_comb begin
      code_in[0] = pop_job.left[0]  > centre;
      code_in[1] = pop_job.mid[0]   > centre;
      code_in[2] = pop_job.right[0] > centre;
      code_in[3] = pop_job.right[1] > centre;
      code_in[4] = pop_job.right[2] > centre;
      code_in[5] = pop_job.mid[2]   > centre;
      code_in[6] = pop_job.left[2]  > centre;
      code_in[7] = pop_job.left[1]  > centre;
   end

   // Output register valid
   always_comb begin
      out_valid_in = out_valid_ff;
      if (take) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         code_ff <= code_in;
         row_ff  <= pop_job.centre_row;
         col_ff  <= pop_job.centre_col;
         last_ff <= pop_job.last_of_frame;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.pattern_code  = code_ff;
   assign rsp.centre_row    = row_ff;
   assign rsp.centre_col    = col_ff;
   assign rsp.last_of_frame = last_ff;

endmodule

// File: rtl/local_binary_pattern_3x3_core.sv
// Top level of the 3x3 local binary pattern core.
// Depends on lbp3_pkg, lbp3_if, lbp3_front, lbp3_fifo and lbp3_back.
//
//   Channel   Direction  Carries
//   req_bus   in         pixel, raster order
//   rsp_bus   out        pattern_code, centre_row, centre_col, last_of_frame
//   csr_bus   in         index 0 image_width, index 1 image_height
//
// One pixel is taken every cycle when the queue has room; codes pass through
// stage 1, the queue and the output register. The line store has one read and
// one write port, used once per pixel each. Reset is synchronous and needs no
// clearing pass. A stalled output fills the two-entry queue before the input stalls.
`timescale 1ns / 1ps

module local_binary_pattern_3x3_core (
   input  logic        clock,
   input  logic        reset,
   lbp3_req_if.sink    req_bus,
   lbp3_rsp_if.source  rsp_bus,
   lbp3_csr_if.sink    csr_bus
);
   import lbp3_pkg::*;

   logic    q_push_valid;
   logic    q_push_ready;
   job_type q_push_job;
   logic    q_pop_valid;
   logic    q_pop_ready;
   job_type q_pop_job;

   lbp3_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .csr        (csr_bus),
      .push_valid (q_push_valid),
      .push_job   (q_push_job),
      .push_ready (q_push_ready)
   );

   lbp3_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push_valid),
      .push_job   (q_push_job),
      .push_ready (q_push_ready),
      .pop_valid  (q_pop_valid),
      .pop_job    (q_pop_job),
      .pop_ready  (q_pop_ready)
   );

   lbp3_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (q_pop_valid),
      .pop_job   (q_pop_job),
      .pop_ready (q_pop_ready),
      .rsp       (rsp_bus)
   );

   // A transaction into the queue leaves it non-empty
   assert property (@(posedge clock) disable iff (reset)
      q_push_valid && q_push_ready |=> q_pop_valid)
      else $error("queue empty after push");

   // Codes only belong to interior pixels
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.centre_row != '0) && (rsp_bus.centre_col != '0))
      else $error("code for a border pixel");

   // The queue never hands over while a result is held back
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.ready |-> !(q_pop_valid && q_pop_ready))
      else $error("result overwritten while stalled");

endmodule
